/* sv/multi_queue_message_mailbox_unit_defines.svh */
// Assertion macros for the message mailbox.
// Included by the modules that carry concurrent checks; needs nothing else.
`ifndef MULTI_QUEUE_MESSAGE_MAILBOX_UNIT_DEFINES_SVH
`define MULTI_QUEUE_MESSAGE_MAILBOX_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define MQMB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mailbox check failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define MQMB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mailbox check failed: next-cycle implication");

`endif

/* sv/mqmb_pkg.sv */
// Shared types and codes of the message mailbox.
// Used by the front end, the back end and the top level; depends on nothing.
package mqmb_pkg;

   typedef enum logic [1:0] {
      ACT_CREATE  = 2'd0,
      ACT_SEND    = 2'd1,
      ACT_RECV    = 2'd2,
      ACT_DESTROY = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_INVALID = 2'd1,
      ST_FULL    = 2'd2,
      ST_EMPTY   = 2'd3
   } status_type;

   // Depth of the command queue between front and back end.
   localparam int FQ_DEPTH = 2;

   // Classified command: length already saturated, payload already masked.
   typedef struct packed {
      action_type  action;
      logic [3:0]  queue_select;
      logic [63:0] payload;
      logic [3:0]  length;
      logic [15:0] sender;
   } cmd_type;

   typedef struct packed {
      status_type  status;
      logic [2:0]  created_queue;
      logic [63:0] data_out;
      logic [3:0]  length_out;
      logic [15:0] sender_out;
      logic [3:0]  active_queues;
   } rsp_type;

endpackage

/* sv/multi_queue_message_mailbox_unit.sv */
// A request transfer is written into the command queue; the back-end sequencer takes it
// in its idle state and registers the result, shown in its output state. A popping receive
// first passes through a read state for the registered ring-storage read. No new command
// is taken until the last result has left; a 2-entry command queue keeps accepting
// requests while a result waits. Reset clears the queue table, pointers, fill levels and
// command queue; ring storage is not cleared and needs no clearing pass.
module multi_queue_message_mailbox_unit
   import mqmb_pkg::*;
#(
   parameter int NUM_QUEUES  = 8,
   parameter int QUEUE_DEPTH = 16,
   parameter int MSG_BYTES   = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [3:0]  req_queue_select,
   input  logic [63:0] req_payload,
   input  logic [7:0]  req_msg_length,
   input  logic [15:0] req_sender_id,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [2:0]  rsp_created_queue,
   output logic [63:0] rsp_data_out,
   output logic [3:0]  rsp_length_out,
   output logic [15:0] rsp_sender_out,
   output logic [3:0]  rsp_active_queues
);

   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd;
   rsp_type rsp;

   mqmb_front #(
      .MSG_BYTES (MSG_BYTES)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_queue_select (req_queue_select),
      .req_payload      (req_payload),
      .req_msg_length   (req_msg_length),
      .req_sender_id    (req_sender_id),
      .cmd_valid        (cmd_valid),
      .cmd              (cmd),
      .cmd_pop          (cmd_pop)
   );

   mqmb_back #(
      .NUM_QUEUES  (NUM_QUEUES),
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .MSG_BYTES   (MSG_BYTES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   assign rsp_status        = rsp.status;
   assign rsp_created_queue = rsp.created_queue;
   assign rsp_data_out      = rsp.data_out;
   assign rsp_length_out    = rsp.length_out;
   assign rsp_sender_out    = rsp.sender_out;
   assign rsp_active_queues = rsp.active_queues;

endmodule

/* sv/mqmb_front.sv */
// Front end of the mailbox: takes request transfers, saturates the length,
// masks the payload and holds the commands in a short queue. Uses mqmb_pkg.
module mqmb_front
   import mqmb_pkg::*;
#(
   parameter int MSG_BYTES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [3:0]  req_queue_select,
   input  logic [63:0] req_payload,
   input  logic [7:0]  req_msg_length,
   input  logic [15:0] req_sender_id,
   output logic        cmd_valid,
   output cmd_type     cmd,
   input  logic        cmd_pop
);

   localparam int FQ_PTR_W = $clog2(FQ_DEPTH);
   localparam int FQ_CNT_W = $clog2(FQ_DEPTH + 1);

   cmd_type                fq_ff [FQ_DEPTH];
   cmd_type                fq_entry_in;
   logic [FQ_PTR_W-1:0]    fq_wr_ptr_ff, fq_wr_ptr_in;
   logic [FQ_PTR_W-1:0]    fq_rd_ptr_ff, fq_rd_ptr_in;
   logic [FQ_CNT_W-1:0]    fq_cnt_ff, fq_cnt_in;
   logic [3:0]             len_sat;
   logic                   push;

   // Saturate the length and clear bytes at or beyond it.
   always_comb begin
      if (req_msg_length > 8'(MSG_BYTES)) begin
         len_sat = 4'(MSG_BYTES);
      end else begin
         len_sat = req_msg_length[3:0];
      end
      fq_entry_in.action       = action_type'(req_action);
      fq_entry_in.queue_select = req_queue_select;
      fq_entry_in.length       = len_sat;
      fq_entry_in.sender       = req_sender_id;
      for (int b = 0; b < 8; b++) begin
         fq_entry_in.payload[b*8 +: 8] = (4'(b) < len_sat) ? req_payload[b*8 +: 8] : 8'h00;
      end
   end

   assign req_stall = (fq_cnt_ff == FQ_CNT_W'(FQ_DEPTH));
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (fq_cnt_ff != '0);
   assign cmd       = fq_ff[fq_rd_ptr_ff];

   always_comb begin
      fq_wr_ptr_in = fq_wr_ptr_ff;
      fq_rd_ptr_in = fq_rd_ptr_ff;
      fq_cnt_in    = fq_cnt_ff;
      if (push) begin
         fq_wr_ptr_in = (fq_wr_ptr_ff == FQ_PTR_W'(FQ_DEPTH - 1)) ? '0 : fq_wr_ptr_ff + 1'b1;
      end
      if (cmd_pop) begin
         fq_rd_ptr_in = (fq_rd_ptr_ff == FQ_PTR_W'(FQ_DEPTH - 1)) ? '0 : fq_rd_ptr_ff + 1'b1;
      end
      if (push && !cmd_pop) begin
         fq_cnt_in = fq_cnt_ff + 1'b1;
      end else if (!push && cmd_pop) begin
         fq_cnt_in = fq_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fq_wr_ptr_ff <= '0;
         fq_rd_ptr_ff <= '0;
         fq_cnt_ff    <= '0;
      end else begin
         fq_wr_ptr_ff <= fq_wr_ptr_in;
         fq_rd_ptr_ff <= fq_rd_ptr_in;
         fq_cnt_ff    <= fq_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fq_ff[fq_wr_ptr_ff] <= fq_entry_in;
      end
   end

endmodule

/* sv/mqmb_back.sv */
// Back end of the mailbox: queue table, ring storage and result register.
// Executes one command at a time. Uses mqmb_pkg and the assertion macros.
`include "multi_queue_message_mailbox_unit_defines.svh"

module mqmb_back
   import mqmb_pkg::*;
#(
   parameter int NUM_QUEUES  = 8,
   parameter int QUEUE_DEPTH = 16,
   parameter int MSG_BYTES   = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   input  cmd_type cmd,
   output logic    cmd_pop,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp
);

   localparam int QIDX_W   = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int CNT_W    = $clog2(NUM_QUEUES + 1);
   localparam int PTR_W    = $clog2(QUEUE_DEPTH);
   localparam int FILL_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int SLOTS    = NUM_QUEUES * QUEUE_DEPTH;
   localparam int ADDR_W   = $clog2(SLOTS);
   localparam int MSG_BITS = 8 * MSG_BYTES;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_READ = 3'b010,
      S_OUT  = 3'b100
   } state_type;

   state_type               state_ff, state_in;
   logic [NUM_QUEUES-1:0]   active_ff, active_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [PTR_W-1:0]        rd_ptr_ff [NUM_QUEUES];
   logic [PTR_W-1:0]        rd_ptr_in [NUM_QUEUES];
   logic [PTR_W-1:0]        wr_ptr_ff [NUM_QUEUES];
   logic [PTR_W-1:0]        wr_ptr_in [NUM_QUEUES];
   logic [FILL_W-1:0]       fill_ff [NUM_QUEUES];
   logic [FILL_W-1:0]       fill_in [NUM_QUEUES];
   rsp_type                 res_ff, res_in;

   logic [MSG_BITS-1:0]     payload_mem [SLOTS];
   logic [3:0]              length_mem  [SLOTS];
   logic [15:0]             sender_mem  [SLOTS];
   logic [MSG_BITS-1:0]     rd_payload_ff;
   logic [3:0]              rd_length_ff;
   logic [15:0]             rd_sender_ff;
   logic                    mem_we, mem_re;
   logic [ADDR_W-1:0]       mem_addr;

   logic [QIDX_W-1:0]       qidx;
   logic                    q_live;
   logic                    free_found;
   logic [QIDX_W-1:0]       free_idx;
   logic [ADDR_W-1:0]       wr_addr, rd_addr;

   function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign qidx   = cmd.queue_select[QIDX_W-1:0];
   assign q_live = ({1'b0, cmd.queue_select} < 5'(NUM_QUEUES)) && active_ff[qidx];

   assign wr_addr = ADDR_W'(int'(qidx) * QUEUE_DEPTH + int'(wr_ptr_ff[qidx]));
   assign rd_addr = ADDR_W'(int'(qidx) * QUEUE_DEPTH + int'(rd_ptr_ff[qidx]));

   // Lowest free queue.
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = NUM_QUEUES - 1; i >= 0; i--) begin
         if (!active_ff[i]) begin
            free_found = 1'b1;
            free_idx   = QIDX_W'(i);
         end
      end
   end

   always_comb begin
      state_in  = state_ff;
      active_in = active_ff;
      cnt_in    = cnt_ff;
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      fill_in   = fill_ff;
      res_in    = res_ff;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_addr  = wr_addr;
      cmd_pop   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop  = 1'b1;
               state_in = S_OUT;
               res_in   = '0;
               case (cmd.action)
                  ACT_CREATE: begin
                     if (free_found) begin
                        active_in[free_idx] = 1'b1;
                        rd_ptr_in[free_idx] = '0;
                        wr_ptr_in[free_idx] = '0;
                        fill_in[free_idx]   = '0;
                        cnt_in              = cnt_ff + 1'b1;
                        res_in.created_queue = 3'(free_idx);
                     end else begin
                        res_in.status = ST_FULL;
                     end
                  end
                  ACT_SEND: begin
                     if (!q_live) begin
                        res_in.status = ST_INVALID;
                     end else if (fill_ff[qidx] == FILL_W'(QUEUE_DEPTH)) begin
                        res_in.status = ST_FULL;
                     end else begin
                        mem_we          = 1'b1;
                        mem_addr        = wr_addr;
                        wr_ptr_in[qidx] = ring_next(wr_ptr_ff[qidx]);
                        fill_in[qidx]   = fill_ff[qidx] + 1'b1;
                     end
                  end
                  ACT_RECV: begin
                     if (!q_live) begin
                        res_in.status = ST_INVALID;
                     end else if (fill_ff[qidx] == '0) begin
                        res_in.status = ST_EMPTY;
                     end else begin
                        mem_re          = 1'b1;
                        mem_addr        = rd_addr;
                        rd_ptr_in[qidx] = ring_next(rd_ptr_ff[qidx]);
                        fill_in[qidx]   = fill_ff[qidx] - 1'b1;
                        state_in        = S_READ;
                     end
                  end
                  ACT_DESTROY: begin
                     if (!q_live) begin
                        res_in.status = ST_INVALID;
                     end else begin
                        active_in[qidx] = 1'b0;
                        cnt_in          = cnt_ff - 1'b1;
                     end
                  end
                  default: res_in.status = ST_INVALID;
               endcase
               res_in.active_queues = 4'(cnt_in);
            end
         end
         S_READ: begin
            // Ring data from the read issued in S_IDLE is now in the read registers.
            res_in.data_out   = 64'(rd_payload_ff);
            res_in.length_out = rd_length_ff;
            res_in.sender_out = rd_sender_ff;
            state_in          = S_OUT;
         end
         S_OUT: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         active_ff <= '0;
         cnt_ff    <= '0;
         for (int i = 0; i < NUM_QUEUES; i++) begin
            rd_ptr_ff[i] <= '0;
            wr_ptr_ff[i] <= '0;
            fill_ff[i]   <= '0;
         end
      end else begin
         state_ff  <= state_in;
         active_ff <= active_in;
         cnt_ff    <= cnt_in;
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         payload_mem[mem_addr] <= cmd.payload[MSG_BITS-1:0];
         length_mem[mem_addr]  <= cmd.length;
         sender_mem[mem_addr]  <= cmd.sender;
      end
      if (mem_re) begin
         rd_payload_ff <= payload_mem[mem_addr];
         rd_length_ff  <= length_mem[mem_addr];
         rd_sender_ff  <= sender_mem[mem_addr];
      end
   end

   assign rsp_valid = (state_ff == S_OUT);
   assign rsp       = res_ff;

   `MQMB_ASSERT_NOW(a_cnt_matches_active, clock, reset, 1'b1,
                    cnt_ff == CNT_W'($countones(active_ff)))
   `MQMB_ASSERT_NEXT(a_read_then_out, clock, reset, state_ff == S_READ, state_ff == S_OUT)
   `MQMB_ASSERT_NOW(a_mem_only_idle, clock, reset, mem_we || mem_re,
                    state_ff == S_IDLE && cmd_valid)
   `MQMB_ASSERT_NOW(a_fail_no_data, clock, reset, rsp_valid && res_ff.status != ST_OK,
                    res_ff.data_out == '0 && res_ff.created_queue == '0)

endmodule
